// ===== rtl/core/bkv_pkg.sv =====
// Shared types and constants for the bucketed key-value table.
// Used by bkv_ctrl, bkv_datapath and the top module under rtl/core; depends on nothing else.
package bkv_pkg;

   localparam int KEY_W   = 31;
   localparam int VALUE_W = 32;

   localparam logic [1:0] ACT_PUT    = 2'd0;
   localparam logic [1:0] ACT_GET    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic signed [VALUE_W-1:0] NOT_FOUND_VALUE = -32'sd1;

   typedef struct packed {
      logic [1:0]                action;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic                      found;
      logic                      status;
   } rsp_type;

   // One way of a bucket row as it sits in the store.
   typedef struct packed {
      logic                      valid;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/bkv_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
module bkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bkv_ctrl.sv =====
// Sequencing state machine for the bucketed key-value table.
// Depends on bkv_pkg for the state, command and status types.
module bkv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bkv_pkg::sts_type sts,
   output bkv_pkg::cmd_type cmd
);

   bkv_pkg::state_type state_ff;
   bkv_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bkv_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bkv_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = bkv_pkg::ST_IDLE;
         end
         bkv_pkg::ST_IDLE: begin
            if (req_valid) state_in = bkv_pkg::ST_EVAL;
         end
         bkv_pkg::ST_EVAL: begin
            if (sts.out_free) state_in = bkv_pkg::ST_IDLE;
         end
         default: state_in = bkv_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         bkv_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         bkv_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         bkv_pkg::ST_EVAL: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/bkv_datapath.sv =====
// Datapath of the bucketed key-value table: bucket store, way compare,
// row update and result register. Depends on bkv_pkg and bkv_ram.
module bkv_datapath #(
   parameter int NUM_BUCKETS = 1024,
   parameter int WAYS        = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  bkv_pkg::cmd_type cmd,
   output bkv_pkg::sts_type sts,
   input  bkv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bkv_pkg::rsp_type rsp_data
);

   localparam int BUCKET_W = $clog2(NUM_BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAYS * $bits(bkv_pkg::entry_type);

   logic [BUCKET_W-1:0] clr_cnt_ff;
   logic [BUCKET_W-1:0] clr_cnt_in;
   bkv_pkg::req_type    req_ff;
   bkv_pkg::req_type    req_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   bkv_pkg::rsp_type    rsp_ff;
   bkv_pkg::rsp_type    rsp_in;

   logic                wr_en;
   logic [BUCKET_W-1:0] wr_addr;
   logic [ROW_W-1:0]    wr_data;
   logic [ROW_W-1:0]    rd_data;

   bkv_pkg::entry_type [WAYS-1:0] row;
   bkv_pkg::entry_type [WAYS-1:0] new_row;
   logic                hit;
   logic                have_free;
   logic [WAY_W-1:0]    hit_idx;
   logic [WAY_W-1:0]    free_idx;
   logic                do_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign clr_cnt_in     = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign sts.clear_done = (clr_cnt_ff == BUCKET_W'(NUM_BUCKETS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_in         = cmd.load ? req_data : req_ff;

   bkv_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_BUCKETS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.load),
      .rd_addr(req_data.key[BUCKET_W-1:0]),
      .rd_data(rd_data)
   );

   assign row = rd_data;

   // Lowest matching way and lowest free way; scanned downward so the
   // lowest index wins.
   always_comb begin
      hit       = 1'b0;
      have_free = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row[w].valid && (row[w].key == req_ff.key)) begin
            hit     = 1'b1;
            hit_idx = WAY_W'(w);
         end
         if (!row[w].valid) begin
            have_free = 1'b1;
            free_idx  = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row  = row;
      do_write = 1'b0;
      case (req_ff.action)
         bkv_pkg::ACT_PUT: begin
            if (hit) begin
               new_row[hit_idx].value = req_ff.value;
               do_write               = 1'b1;
            end else if (have_free) begin
               new_row[free_idx].valid = 1'b1;
               new_row[free_idx].key   = req_ff.key;
               new_row[free_idx].value = req_ff.value;
               do_write                = 1'b1;
            end
         end
         bkv_pkg::ACT_REMOVE: begin
            if (hit) begin
               new_row[hit_idx].valid = 1'b0;
               do_write               = 1'b1;
            end
         end
         default: begin
            do_write = 1'b0;
         end
      endcase
   end

   assign wr_en   = cmd.clear || (cmd.commit && do_write);
   assign wr_addr = cmd.clear ? clr_cnt_ff : req_ff.key[BUCKET_W-1:0];
   assign wr_data = cmd.clear ? '0 : ROW_W'(new_row);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.found      = hit;
         rsp_in.status     = (req_ff.action == bkv_pkg::ACT_PUT) && !hit && !have_free;
         rsp_in.read_value = ((req_ff.action == bkv_pkg::ACT_GET) && hit)
                             ? row[hit_idx].value : bkv_pkg::NOT_FOUND_VALUE;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/bucketed_key_value_table_top.sv =====
// Bucketed key-value table: a bucketed hash map with a fixed number of ways per bucket.
// An accepted request loads the request register and the registered read of the bucket
// row store; its response is registered at commit, which waits while a held response is
// stalled. A new request is not taken until the previous one commits. After reset a
// clearing pass writes every row empty, with req_stall held high until it finishes.
// Depends on bkv_pkg, bkv_ctrl, bkv_datapath.
module bucketed_key_value_table_top #(
   parameter int NUM_BUCKETS = 1024,
   parameter int WAYS        = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bkv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bkv_pkg::rsp_type rsp_data
);

   // Besides the request handshake, the controller sees only the command and status
   // groups; all bucket state, the way compare and the response register live in the datapath.
   bkv_pkg::cmd_type cmd;
   bkv_pkg::sts_type sts;

   // Each transaction: the bucket row is read at acceptance, and at commit the
   // ways are compared, the row is written back and the response register is
   // loaded. A waiting response does not block the next transaction from being
   // accepted; only its commit waits.
   bkv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // The bucket index is the low bits of the key, since the bucket count is
   // a power of two.
   bkv_datapath #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .WAYS       (WAYS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
